/* rtl/gsi_pkg.sv */
// Shared types and constants of the gamepad script interpreter.
package gsi_pkg;

  localparam logic [3:0]  HAT_NEUTRAL  = 4'd8;
  localparam logic [7:0]  AXIS_CENTER  = 8'd128;
  localparam logic [3:0]  BUTTON_COUNT = 4'd14;
  localparam logic [7:0]  VERSION_RST  = 8'h03;
  localparam logic [11:0] TAP_HOLD_RST = 12'd25;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_MAGIC2  = 4'd2,
    PH_MAGIC3  = 4'd3,
    PH_VERSION = 4'd4,
    PH_PAD     = 4'd5,
    PH_RUN     = 4'd6,
    PH_DELAY   = 4'd7,
    PH_STICK   = 4'd8,
    PH_REP     = 4'd9,
    PH_END     = 4'd10,
    PH_ERR     = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_WAIT   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE_MAGIC = 2'd0,
    ERR_VERSION    = 2'd1,
    ERR_RECORD     = 2'd2
  } err_e;

  typedef struct packed {
    phase_e          phase;
    logic [7:0]      pending;
    logic [15:0]     buttons;
    logic [3:0]      hat;
    logic [3:0][7:0] axes;
    logic [7:0]      last_short;
  } state_t;

  typedef struct packed {
    kind_e           kind;
    err_e            err;
    logic [15:0]     buttons;
    logic [3:0]      dpad;
    logic [3:0][7:0] axes;
    logic [11:0]     wait_ms;
    logic [11:0]     rep;
    logic            last;
  } result_t;

  function automatic state_t reset_state();
    state_t s;
    s.phase      = PH_MAGIC0;
    s.pending    = '0;
    s.buttons    = '0;
    s.hat        = HAT_NEUTRAL;
    s.axes       = {4{AXIS_CENTER}};
    s.last_short = '0;
    return s;
  endfunction

endpackage

/* rtl/gsi_decode.sv */
// Combinational decoder: one stream byte against the current state gives the
// next state and up to two results.
module gsi_decode import gsi_pkg::*; (
  input  state_t      st_i,
  input  logic [7:0]  byte_i,
  input  logic        restart_i,
  input  logic        abort_i,
  input  logic [7:0]  version_i,
  input  logic [11:0] tap_hold_i,
  output state_t      st_o,
  output logic [1:0]  count_o,
  output result_t     r0_o,
  output result_t     r1_o
);

  function automatic logic [15:0] btn_bit(input logic [3:0] n);
    logic [15:0] b;
    case (n)
      4'd0:    b = 16'h0004;
      4'd1:    b = 16'h0002;
      4'd2:    b = 16'h0008;
      4'd3:    b = 16'h0001;
      4'd4:    b = 16'h0010;
      4'd5:    b = 16'h0020;
      4'd6:    b = 16'h0040;
      4'd7:    b = 16'h0080;
      4'd8:    b = 16'h0100;
      4'd9:    b = 16'h0200;
      4'd10:   b = 16'h0400;
      4'd11:   b = 16'h0800;
      4'd12:   b = 16'h1000;
      4'd13:   b = 16'h2000;
      default: b = 16'h0000;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] i);
    logic [7:0] m;
    case (i)
      2'd0:    m = 8'h54;
      2'd1:    m = 8'h44;
      2'd2:    m = 8'h4C;
      default: m = 8'h44;
    endcase
    return m;
  endfunction

  function automatic logic short_valid(input logic [7:0] rec);
    logic v;
    case (rec[7:4])
      4'h1, 4'h2, 4'h8:        v = (rec[3:0] < BUTTON_COUNT);
      4'h3, 4'h4, 4'h5, 4'h9:  v = 1'b1;
      default:                 v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic result_t mk(input kind_e k, input err_e e, input logic [11:0] w,
                                 input logic [11:0] rep, input state_t s);
    result_t r;
    r.kind    = k;
    r.err     = e;
    r.buttons = s.buttons;
    r.dpad    = s.hat;
    r.axes    = s.axes;
    r.wait_ms = w;
    r.rep     = rep;
    r.last    = 1'b0;
    return r;
  endfunction

  always_comb begin
    state_t      s;
    state_t      t;
    logic [1:0]  n;
    logic        fail;
    err_e        code;
    logic        do_rep;
    logic        do_run;
    logic [7:0]  rec;
    logic [11:0] rep;
    logic [11:0] wide;
    logic [15:0] bit_s;
    result_t     a;
    result_t     b;

    s      = st_i;
    t      = st_i;
    n      = 2'd0;
    fail   = 1'b0;
    code   = ERR_NONE_MAGIC;
    do_rep = 1'b0;
    do_run = 1'b0;
    rec    = byte_i;
    rep    = 12'd1;
    wide   = {st_i.pending[3:0], byte_i};
    a      = mk(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, 12'd1, st_i);
    b      = a;

    if (restart_i) begin
      s.phase      = PH_MAGIC0;
      s.pending    = '0;
      s.last_short = '0;
    end else if (abort_i) begin
      if (st_i.phase != PH_END && st_i.phase != PH_ERR) begin
        s.buttons = '0;
        s.hat     = HAT_NEUTRAL;
        s.axes    = {4{AXIS_CENTER}};
        s.phase   = PH_END;
        a = mk(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, 12'd1, s);
        b = mk(KIND_END, ERR_NONE_MAGIC, 12'd0, 12'd1, s);
        n = 2'd2;
      end
    end else begin
      case (st_i.phase)
        PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
          if (byte_i != magic_byte(st_i.phase[1:0])) begin
            fail = 1'b1;
            code = ERR_NONE_MAGIC;
          end else begin
            s.phase = phase_e'(st_i.phase + 4'd1);
          end
        end
        PH_VERSION: begin
          if (byte_i != version_i) begin
            fail = 1'b1;
            code = ERR_VERSION;
          end else begin
            s.phase = PH_PAD;
          end
        end
        PH_PAD: s.phase = PH_RUN;
        PH_DELAY: begin
          s.phase = PH_RUN;
          a = mk(KIND_WAIT, ERR_NONE_MAGIC, wide, 12'd1, s);
          n = 2'd1;
        end
        PH_STICK: begin
          s.phase = PH_RUN;
          s.axes[st_i.pending[1:0]] = byte_i;
          a = mk(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, 12'd1, s);
          n = 2'd1;
        end
        PH_REP: begin
          s.phase = PH_RUN;
          do_rep  = 1'b1;
          rep     = wide;
        end
        PH_RUN: begin
          case (byte_i[7:4])
            4'h0: begin
              s.phase = PH_END;
              a = mk(KIND_END, ERR_NONE_MAGIC, 12'd0, 12'd1, s);
              n = 2'd1;
            end
            4'h6: begin
              s.pending = byte_i;
              s.phase   = PH_DELAY;
            end
            4'h7: begin
              if (byte_i[3:0] >= 4'd4) begin
                fail = 1'b1;
                code = ERR_RECORD;
              end else begin
                s.pending = byte_i;
                s.phase   = PH_STICK;
              end
            end
            4'hE: begin
              do_rep = 1'b1;
              rep    = {8'd0, byte_i[3:0]};
            end
            4'hF: begin
              s.pending = byte_i;
              s.phase   = PH_REP;
            end
            default: begin
              if (!short_valid(byte_i)) begin
                fail = 1'b1;
                code = ERR_RECORD;
              end else begin
                s.last_short = byte_i;
                do_run       = 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end

    if (do_rep && rep != 12'd0) begin
      if (!short_valid(st_i.last_short)) begin
        fail = 1'b1;
        code = ERR_RECORD;
      end else begin
        do_run = 1'b1;
        rec    = st_i.last_short;
      end
    end

    bit_s = (rec[3:0] < BUTTON_COUNT) ? btn_bit(rec[3:0]) : 16'h0000;

    if (fail) begin
      s.phase = PH_ERR;
      a = mk(KIND_ERROR, code, 12'd0, 12'd1, s);
      n = 2'd1;
    end else if (do_run) begin
      case (rec[7:4])
        4'h1: s.buttons = s.buttons | bit_s;
        4'h2: s.buttons = s.buttons & ~bit_s;
        4'h3: s.hat = rec[3:0];
        4'h4: s.hat = HAT_NEUTRAL;
        4'h5: begin
          s.buttons = '0;
          s.hat     = HAT_NEUTRAL;
          s.axes    = {4{AXIS_CENTER}};
        end
        default: ;
      endcase
      if (rec[7:4] == 4'h8) begin
        t = s;
        t.buttons = s.buttons | bit_s;
        a = mk(KIND_REPORT, ERR_NONE_MAGIC, tap_hold_i, rep, t);
        s.buttons = t.buttons & ~bit_s;
        b = mk(KIND_REPORT, ERR_NONE_MAGIC, tap_hold_i, rep, s);
        n = 2'd2;
      end else if (rec[7:4] == 4'h9) begin
        t = s;
        t.hat = rec[3:0];
        a = mk(KIND_REPORT, ERR_NONE_MAGIC, tap_hold_i, rep, t);
        s.hat = HAT_NEUTRAL;
        b = mk(KIND_REPORT, ERR_NONE_MAGIC, tap_hold_i, rep, s);
        n = 2'd2;
      end else begin
        a = mk(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, rep, s);
        n = 2'd1;
      end
    end

    a.last = (n == 2'd1);
    b.last = 1'b1;

    st_o    = s;
    count_o = n;
    r0_o    = a;
    r1_o    = b;
  end

endmodule

/* rtl/gamepad_script_interpreter.sv */
// Top level of the gamepad script interpreter: stream ports, registers, result stage.
//
// Bytes of a controller script enter on the s_axis channel, one request per
// byte; tuser carries the restart and abort flags. Each request yields zero,
// one or two results on the m_axis channel, with tlast on the last result of
// the request. The two configuration registers (expected version at byte
// address 0, tap hold time at 4) are written through the APB port; the user
// must write them only while the block is idle, which the block does not enforce.
// An accepted byte waits in an input register, is decoded combinationally and
// its results are loaded into a two-entry result register, from which the
// first result is offered on the m_axis channel.
// A byte is accepted every cycle while the results drain; a request with two
// results holds the result register until both results are taken, and the
// next byte that yields a result waits until the last of them is taken.
// When the receiver stalls, the result register holds and bytes that yield
// no result keep passing; the next byte that yields a result waits in the
// input register, and s_axis_tready then drops.
// Reset restores the register defaults, empties both stages and returns the
// interpreter to the start of the header with neutral buttons, hat and axes.
module gamepad_script_interpreter import gsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,  // [0] restart, [1] abort
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] error_code, [17:2] buttons, [21:18] dpad, [29:22] left_x,
  // [37:30] left_y, [45:38] right_x, [53:46] right_y, [65:54] wait_ms,
  // [77:66] repeat_count, [79:78] zero
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  version_q;
  logic [11:0] tap_hold_q;
  state_t      st_q, st_d;

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_restart_q;
  logic        in_abort_q;

  logic        pv_q;
  logic        two_q;
  logic        idx_q;
  result_t     r0_q, r1_q;

  logic [1:0]  dec_n;
  result_t     dec_r0, dec_r1;
  result_t     cur;
  logic        last_take;
  logic        out_free;
  logic        adv;
  logic        in_take;

  gsi_decode u_decode (
    .st_i       (st_q),
    .byte_i     (in_byte_q),
    .restart_i  (in_restart_q),
    .abort_i    (in_abort_q),
    .version_i  (version_q),
    .tap_hold_i (tap_hold_q),
    .st_o       (st_d),
    .count_o    (dec_n),
    .r0_o       (dec_r0),
    .r1_o       (dec_r1)
  );

  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? {20'd0, tap_hold_q} : {24'd0, version_q};

  assign last_take = pv_q && m_axis_tready && (idx_q || !two_q);
  assign out_free  = !pv_q || last_take;
  assign adv       = in_v_q && (dec_n == 2'd0 || out_free);
  assign s_axis_tready = !in_v_q || adv;
  assign in_take   = s_axis_tvalid && s_axis_tready;

  assign cur           = idx_q ? r1_q : r0_q;
  assign m_axis_tvalid = pv_q;
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = cur.last;
  assign m_axis_tdata  = {2'b00, cur.rep, cur.wait_ms, cur.axes[3], cur.axes[2],
                          cur.axes[1], cur.axes[0], cur.dpad, cur.buttons, cur.err};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q  <= VERSION_RST;
      tap_hold_q <= TAP_HOLD_RST;
      st_q       <= reset_state();
      in_v_q     <= 1'b0;
      pv_q       <= 1'b0;
      two_q      <= 1'b0;
      idx_q      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2]) begin
          tap_hold_q <= pwdata[11:0];
        end else begin
          version_q <= pwdata[7:0];
        end
      end
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        st_q <= st_d;
      end
      if (adv && dec_n != 2'd0) begin
        pv_q  <= 1'b1;
        two_q <= (dec_n == 2'd2);
        idx_q <= 1'b0;
      end else if (last_take) begin
        pv_q  <= 1'b0;
        idx_q <= 1'b0;
      end else if (pv_q && m_axis_tready) begin
        idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser[0];
      in_abort_q   <= s_axis_tuser[1];
    end
    if (adv && dec_n != 2'd0) begin
      r0_q <= dec_r0;
      r1_q <= dec_r1;
    end
  end

  a_idx_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (two_q || !idx_q))
    else $error("second result selected in a one-result group");

  a_abort_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_restart_q && in_abort_q |=> st_q.phase == PH_END || st_q.phase == PH_ERR)
    else $error("abort did not leave the stream terminal");

  a_error_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && dec_n != 2'd0 && dec_r0.kind == KIND_ERROR |=> st_q.phase == PH_ERR)
    else $error("error result without error phase");

  a_code_only_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (cur.kind == KIND_ERROR || cur.err == ERR_NONE_MAGIC))
    else $error("error code set on a non-error result");

endmodule

/* tb/gamepad_script_interpreter_test.sv */
// Self-checking testbench for the gamepad script interpreter: stream requests, APB setup, checks.
`timescale 1ns / 100ps

module gamepad_script_interpreter_test;
  import gsi_pkg::*;

  localparam logic [3:0] OP_END         = 4'h0;
  localparam logic [3:0] OP_PRESS       = 4'h1;
  localparam logic [3:0] OP_RELEASE     = 4'h2;
  localparam logic [3:0] OP_HAT         = 4'h3;
  localparam logic [3:0] OP_HAT_NEUTRAL = 4'h4;
  localparam logic [3:0] OP_RELEASE_ALL = 4'h5;
  localparam logic [3:0] OP_DELAY       = 4'h6;
  localparam logic [3:0] OP_STICK       = 4'h7;
  localparam logic [3:0] OP_TAP         = 4'h8;
  localparam logic [3:0] OP_HAT_TAP     = 4'h9;
  localparam logic [3:0] OP_REPEAT      = 4'hE;
  localparam logic [3:0] OP_REPEAT_LONG = 4'hF;

  localparam int REG_EXPECTED_VERSION = 0;
  localparam int REG_TAP_HOLD         = 1;

  localparam logic [3:0][7:0] HEADER_MAGIC = {8'h44, 8'h4C, 8'h44, 8'h54};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic [1:0]  s_axis_tuser = 2'b00;  // [0] restart, [1] abort
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] error_code, [17:2] buttons, [21:18] dpad, [29:22] left_x,
  // [37:30] left_y, [45:38] right_x, [53:46] right_y, [65:54] wait_ms,
  // [77:66] repeat_count, [79:78] zero
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;  // [1:0] kind
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  gamepad_script_interpreter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  logic [7:0]      cfg_version = VERSION_RST;
  logic [11:0]     cfg_tap_hold = TAP_HOLD_RST;
  phase_e          ph = PH_MAGIC0;
  logic [7:0]      pend = 8'h00;
  logic [15:0]     held = 16'h0000;
  logic [3:0]      hat = HAT_NEUTRAL;
  logic [3:0][7:0] axes = {4{AXIS_CENTER}};
  logic [7:0]      last_short = 8'h00;

  result_t due_results[$];
  result_t oldest;
  int      step_count;
  kind_e   step_kind;
  err_e    step_err;

  int send_idle_pct = 32;
  int recv_idle_pct = 48;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatches = 0;

  function automatic logic [15:0] button_bit(logic [3:0] n);
    case (n)
      4'd0: return 16'h0004;
      4'd1: return 16'h0002;
      4'd2: return 16'h0008;
      4'd3: return 16'h0001;
      default: return (n < BUTTON_COUNT) ? (16'h0001 << n) : 16'h0000;
    endcase
  endfunction

  function automatic logic short_ok(logic [7:0] rec);
    case (rec[7:4])
      OP_PRESS, OP_RELEASE, OP_TAP: return rec[3:0] < BUTTON_COUNT;
      OP_HAT, OP_HAT_NEUTRAL, OP_RELEASE_ALL, OP_HAT_TAP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(kind_e k, err_e e, logic [11:0] w, logic [11:0] r);
    result_t x;
    x.kind = k;
    x.err = e;
    x.buttons = held;
    x.dpad = hat;
    x.axes = axes;
    x.wait_ms = w;
    x.rep = r;
    x.last = 1'b0;
    due_results.push_back(x);
  endfunction

  function automatic void raise(err_e code);
    ph = PH_ERR;
    emit(KIND_ERROR, code, 12'd0, 12'd1);
  endfunction

  function automatic void neutral_report();
    held = 16'h0000;
    hat = HAT_NEUTRAL;
    axes = {4{AXIS_CENTER}};
  endfunction

  function automatic void run_short(logic [7:0] rec, logic [11:0] rep);
    logic [15:0] bit_mask;
    bit_mask = button_bit(rec[3:0]);
    case (rec[7:4])
      OP_PRESS: held |= bit_mask;
      OP_RELEASE: held &= ~bit_mask;
      OP_HAT: hat = rec[3:0];
      OP_HAT_NEUTRAL: hat = HAT_NEUTRAL;
      OP_RELEASE_ALL: neutral_report();
      OP_TAP: begin
        held |= bit_mask;
        emit(KIND_REPORT, ERR_NONE_MAGIC, cfg_tap_hold, rep);
        held &= ~bit_mask;
        emit(KIND_REPORT, ERR_NONE_MAGIC, cfg_tap_hold, rep);
        return;
      end
      default: begin
        hat = rec[3:0];
        emit(KIND_REPORT, ERR_NONE_MAGIC, cfg_tap_hold, rep);
        hat = HAT_NEUTRAL;
        emit(KIND_REPORT, ERR_NONE_MAGIC, cfg_tap_hold, rep);
        return;
      end
    endcase
    emit(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, rep);
  endfunction

  function automatic void repeat_last(logic [11:0] count);
    if (count == 12'd0) return;
    if (!short_ok(last_short)) raise(ERR_RECORD);
    else run_short(last_short, count);
  endfunction

  function automatic void interpret_byte(logic [7:0] b, logic rs, logic ab);
    int queued_at_start;
    logic [11:0] wide;
    queued_at_start = due_results.size();
    wide = {pend[3:0], b};
    if (rs) begin
      ph = PH_MAGIC0;
      pend = 8'h00;
      last_short = 8'h00;
    end else if (ab) begin
      if (ph != PH_END && ph != PH_ERR) begin
        neutral_report();
        ph = PH_END;
        emit(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, 12'd1);
        emit(KIND_END, ERR_NONE_MAGIC, 12'd0, 12'd1);
      end
    end else begin
      case (ph)
        PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
          if (b != HEADER_MAGIC[ph[1:0]]) raise(ERR_NONE_MAGIC);
          else ph = phase_e'(ph + 4'd1);
        end
        PH_VERSION: begin
          if (b != cfg_version) raise(ERR_VERSION);
          else ph = PH_PAD;
        end
        PH_PAD: ph = PH_RUN;
        PH_DELAY: begin
          ph = PH_RUN;
          emit(KIND_WAIT, ERR_NONE_MAGIC, wide, 12'd1);
        end
        PH_STICK: begin
          ph = PH_RUN;
          axes[pend[1:0]] = b;
          emit(KIND_REPORT, ERR_NONE_MAGIC, 12'd0, 12'd1);
        end
        PH_REP: begin
          ph = PH_RUN;
          repeat_last(wide);
        end
        PH_RUN: begin
          case (b[7:4])
            OP_END: begin
              ph = PH_END;
              emit(KIND_END, ERR_NONE_MAGIC, 12'd0, 12'd1);
            end
            OP_DELAY: begin
              pend = b;
              ph = PH_DELAY;
            end
            OP_STICK: begin
              if (b[3:0] >= 4'd4) begin
                raise(ERR_RECORD);
              end else begin
                pend = b;
                ph = PH_STICK;
              end
            end
            OP_REPEAT: repeat_last({8'd0, b[3:0]});
            OP_REPEAT_LONG: begin
              pend = b;
              ph = PH_REP;
            end
            default: begin
              if (!short_ok(b)) begin
                raise(ERR_RECORD);
              end else begin
                last_short = b;
                run_short(b, 12'd1);
              end
            end
          endcase
        end
        default: ;
      endcase
    end
    step_count = due_results.size() - queued_at_start;
    if (step_count > 0) begin
      due_results[$].last = 1'b1;
      step_kind = due_results[$].kind;
      step_err = due_results[$].err;
    end
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result with none pending: kind %0d, data 0x%0h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        oldest = due_results.pop_front();
        results_checked++;
        compare_field("kind", oldest.kind, m_axis_tuser);
        compare_field("error_code", oldest.err, m_axis_tdata[1:0]);
        compare_field("buttons", oldest.buttons, m_axis_tdata[17:2]);
        compare_field("dpad", oldest.dpad, m_axis_tdata[21:18]);
        compare_field("left_x", oldest.axes[0], m_axis_tdata[29:22]);
        compare_field("left_y", oldest.axes[1], m_axis_tdata[37:30]);
        compare_field("right_x", oldest.axes[2], m_axis_tdata[45:38]);
        compare_field("right_y", oldest.axes[3], m_axis_tdata[53:46]);
        compare_field("wait_ms", oldest.wait_ms, m_axis_tdata[65:54]);
        compare_field("repeat_count", oldest.rep, m_axis_tdata[77:66]);
        compare_field("group_last", oldest.last, m_axis_tlast);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      interpret_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs, input logic ab);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= {ab, rs};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_EXPECTED_VERSION) cfg_version = val[7:0];
    else cfg_tap_hold = val[11:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    compare_field(idx == REG_EXPECTED_VERSION ? "expected_version" : "tap_hold_ms", val, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic play_script();
    int records;
    int pick;
    logic [3:0] op;
    logic [3:0] n;
    logic [7:0] hb;
    records = $urandom_range(30, 4);
    send_byte(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
    for (int i = 0; i < 6; i++) begin
      if (i < 4) hb = HEADER_MAGIC[i];
      else if (i == 4) hb = cfg_version;
      else hb = 8'($urandom_range(255));
      if ($urandom_range(19) == 0) hb = 8'($urandom_range(255));
      send_byte(hb, 1'b0, 1'b0);
    end
    for (int r = 0; r < records; r++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        case ($urandom_range(6))
          0: op = OP_PRESS;
          1: op = OP_RELEASE;
          2: op = OP_HAT;
          3: op = OP_HAT_NEUTRAL;
          4: op = OP_RELEASE_ALL;
          5: op = OP_TAP;
          default: op = OP_HAT_TAP;
        endcase
        if (op == OP_PRESS || op == OP_RELEASE || op == OP_TAP) n = 4'($urandom_range(13));
        else n = 4'($urandom_range(15));
        send_byte({op, n}, 1'b0, 1'b0);
      end else if (pick < 55) begin
        send_byte({OP_DELAY, 4'($urandom_range(15))}, 1'b0, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (pick < 67) begin
        send_byte({OP_STICK, 4'($urandom_range(3))}, 1'b0, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (pick < 77) begin
        send_byte({OP_REPEAT, 4'($urandom_range(15))}, 1'b0, 1'b0);
      end else if (pick < 85) begin
        n = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd0;
        send_byte({OP_REPEAT_LONG, n}, 1'b0, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (pick < 93) begin
        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (pick < 96) begin
        send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      end else begin
        send_byte({OP_END, 4'($urandom_range(15))}, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int items);
    int start;
    int scripts;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = bytes_sent;
    scripts = 0;
    while (bytes_sent - start < items) begin
      play_script();
      scripts++;
      if (scripts == 5) hold_until_drained();
    end
  endtask

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       abort;
    logic       pinned;
    logic [1:0] count;
    kind_e      kind;
    err_e       err;
  } script_row_t;

  localparam int DIRECTED_ROWS = 27;

  script_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h54, 1'b0, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h44, 1'b0, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h4C, 1'b0, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h44, 1'b0, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h07, 1'b0, 1'b0, 1'b1, 2'd1, KIND_ERROR,  ERR_VERSION},
    '{8'h00, 1'b0, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h55, 1'b0, 1'b0, 1'b1, 2'd1, KIND_ERROR,  ERR_NONE_MAGIC},
    '{8'h00, 1'b1, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h54, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h44, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h4C, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h44, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h03, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h1D, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h8D, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h9F, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h73, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h60, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'hE0, 1'b0, 1'b0, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, KIND_REPORT, ERR_NONE_MAGIC},
    '{8'h00, 1'b0, 1'b1, 1'b1, 2'd2, KIND_END,    ERR_NONE_MAGIC},
    '{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, KIND_REPORT, ERR_NONE_MAGIC}
  };

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(directed_rows[i].data, directed_rows[i].restart, directed_rows[i].abort);
      if (directed_rows[i].pinned) begin
        compare_field("result count", directed_rows[i].count, step_count);
        if (directed_rows[i].count != 2'd0) begin
          compare_field("final kind", directed_rows[i].kind, step_kind);
          compare_field("final error_code", directed_rows[i].err, step_err);
        end
      end
    end
    settle();
    write_reg(REG_EXPECTED_VERSION, 32'd0);
    write_reg(REG_TAP_HOLD, 32'd4095);
    run_phase(32, 48, 350);
    settle();
    write_reg(REG_EXPECTED_VERSION, 32'd255);
    write_reg(REG_TAP_HOLD, 32'd0);
    run_phase(48, 32, 350);
    settle();
    write_reg(REG_EXPECTED_VERSION, 32'($urandom_range(255)));
    write_reg(REG_TAP_HOLD, 32'($urandom_range(4095)));
    run_phase(0, 0, 350);
    settle();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d script bytes under four register settings and three idle patterns;",
             bytes_sent);
    $display("%0d results compared, %0d field mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("gamepad_script_interpreter: match");
    end else begin
      $display("gamepad_script_interpreter: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d results still pending.", due_results.size());
    $display("gamepad_script_interpreter: mismatch");
    $finish;
  end

endmodule
